// ----- rtl/asio_pkg.sv -----
// asio_pkg: shared widths, event codes, command bytes and register indexes
// for the addressed serial I/O command slave. No dependencies.
`default_nettype none

package asio_pkg;

  localparam int ADDR_W      = 7;
  localparam int BYTE_W      = 8;
  localparam int ADC_W       = 10;
  localparam int LED_W       = 19;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 19;

  localparam int REPLY_DEPTH = 2;
  localparam int REPLY_SEL_W = $clog2(REPLY_DEPTH);
  localparam int REPLY_IDX_W = $clog2(REPLY_DEPTH + 1);

  localparam logic [ADDR_W-1:0] START_ADDR_RESET = 7'd1;
  localparam logic [LED_W-1:0]  LED_HOLD_RESET   = 19'd500000;

  // Event codes carried by in_operation
  typedef enum logic [OP_W-1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_READY = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Command bytes
  localparam logic [BYTE_W-1:0] ADDR_FLAG    = 8'h80;
  localparam logic [BYTE_W-1:0] CMD_SET_OUT  = 8'h10;
  localparam logic [BYTE_W-1:0] CMD_GET_DIN  = 8'h20;
  localparam logic [BYTE_W-1:0] CMD_GET_AIN0 = 8'h30;
  localparam logic [BYTE_W-1:0] CMD_GET_AIN3 = 8'h33;
  localparam logic [BYTE_W-1:0] CMD_SET_ADDR = 8'h40;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_ADDR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_HOLD   = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/addressed_serial_io_command_slave.sv -----
// addressed_serial_io_command_slave: byte-protocol command slave for an I/O
// board, one event per item, one result per item. Depends on asio_pkg.
`default_nettype none

// Channel | direction | handshake             | payload
// --------+-----------+-----------------------+--------------------------------
// in_     | input     | in_valid / in_stall   | operation, rx_byte, inputs, adc
// out_    | output    | out_valid / out_stall | tx, outputs, led, address
// cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per cycle while the sink does not stall the result register. An
// accepted item updates the state and loads the result register at the same edge.
// The result register is the only buffer; in_stall is high while it holds
// an item that the sink stalls, so an item can enter in the cycle its
// predecessor leaves. Reset (rst_n low, synchronous) holds in_stall high
// and cfg_ready low, empties the result register and loads the address.

module addressed_serial_io_command_slave
  import asio_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,

  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  [OP_W-1:0]        in_operation,
  input  wire  [BYTE_W-1:0]      in_rx_byte,
  input  wire  [BYTE_W-1:0]      in_digital_inputs,
  input  wire  [ADC_W-1:0]       in_analog_ch0,
  input  wire  [ADC_W-1:0]       in_analog_ch1,
  input  wire  [ADC_W-1:0]       in_analog_ch2,
  input  wire  [ADC_W-1:0]       in_analog_ch3,
  input  wire                    in_button_held,
  input  wire                    in_address_store_ok,

  output logic                   out_valid,
  input  wire                    out_stall,
  output logic                   out_tx_valid,
  output logic [BYTE_W-1:0]      out_tx_byte,
  output logic                   out_tx_enabled,
  output logic                   out_outputs_write,
  output logic [BYTE_W-1:0]      out_outputs_value,
  output logic                   out_led_lit,
  output logic [ADDR_W-1:0]      out_current_address,

  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire  [CFG_IDX_W-1:0]   cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data
);

  // Command machine phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WAIT_CMD,
    PH_WAIT_OUT,
    PH_WAIT_ADDR,
    PH_SENDING,
    PH_READ_PENDING
  } phase_t;

  // Command latched from the command byte
  typedef enum logic [2:0] {
    PC_NONE,
    PC_SET_OUT,
    PC_DIN,
    PC_AIN0,
    PC_AIN1,
    PC_AIN2,
    PC_AIN3,
    PC_SET_ADDR
  } pend_t;

  phase_t                  phase_r, phase_nxt;
  pend_t                   pend_r, pend_nxt;
  logic [BYTE_W-1:0]       reply_r   [REPLY_DEPTH];
  logic [BYTE_W-1:0]       reply_nxt [REPLY_DEPTH];
  logic [REPLY_IDX_W-1:0]  ridx_r, ridx_nxt;
  logic [ADDR_W-1:0]       own_r, own_nxt;
  logic [LED_W-1:0]        led_r, led_nxt;
  logic                    txon_r, txon_nxt;
  logic [ADDR_W-1:0]       start_r, start_nxt;
  logic [LED_W-1:0]        hold_r, hold_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    tx_valid_r, tx_valid_nxt;
  logic [BYTE_W-1:0]       tx_byte_r, tx_byte_nxt;
  logic                    tx_en_r, tx_en_nxt;
  logic                    owr_r, owr_nxt;
  logic [BYTE_W-1:0]       oval_r, oval_nxt;
  logic                    lit_r, lit_nxt;
  logic [ADDR_W-1:0]       caddr_r, caddr_nxt;

  logic                    accept;
  logic                    cfg_wr;
  logic                    is_ain;
  logic                    done;
  logic [ADC_W-1:0]        adc_sel;

  // The result register is the skid stage: stall only in reset or while it is
  // full and the sink holds it.
  assign in_stall  = !rst_n || (out_valid_r && out_stall);
  assign cfg_ready = rst_n;
  assign accept    = in_valid && !in_stall;
  assign cfg_wr    = cfg_valid && cfg_ready;

  assign is_ain = (pend_r == PC_AIN0) || (pend_r == PC_AIN1) ||
                  (pend_r == PC_AIN2) || (pend_r == PC_AIN3);

  // Analog channel picked by the latched read command
  always_comb begin
    case (pend_r)
      PC_AIN0: adc_sel = in_analog_ch0;
      PC_AIN1: adc_sel = in_analog_ch1;
      PC_AIN2: adc_sel = in_analog_ch2;
      PC_AIN3: adc_sel = in_analog_ch3;
      default: adc_sel = in_analog_ch0;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    pend_nxt   = pend_r;
    reply_nxt  = reply_r;
    ridx_nxt   = ridx_r;
    own_nxt    = own_r;
    led_nxt    = led_r;
    txon_nxt   = txon_r;
    start_nxt  = start_r;
    hold_nxt   = hold_r;
    done       = 1'b1;

    tx_valid_nxt = 1'b0;
    tx_byte_nxt  = '0;
    owr_nxt      = 1'b0;
    oval_nxt     = '0;
    lit_nxt      = 1'b0;

    if (accept) begin
      case (op_t'(in_operation))
        OP_BYTE: begin
          case (phase_r)
            PH_IDLE: begin
              if (in_rx_byte[BYTE_W-1] && (in_rx_byte[ADDR_W-1:0] == own_r)) begin
                phase_nxt = PH_WAIT_CMD;
              end
            end
            PH_WAIT_CMD: begin
              if (in_rx_byte == CMD_SET_OUT) begin
                pend_nxt  = PC_SET_OUT;
                phase_nxt = PH_WAIT_OUT;
              end else if (in_rx_byte == CMD_SET_ADDR) begin
                pend_nxt  = PC_SET_ADDR;
                phase_nxt = PH_WAIT_ADDR;
              end else if (in_rx_byte == CMD_GET_DIN) begin
                pend_nxt  = PC_DIN;
                phase_nxt = PH_READ_PENDING;
              end else if (in_rx_byte inside {[CMD_GET_AIN0:CMD_GET_AIN3]}) begin
                // low two bits of the command pick the channel
                pend_nxt  = pend_t'(3'(PC_AIN0) + {1'b0, in_rx_byte[1:0]});
                phase_nxt = PH_READ_PENDING;
              end else begin
                pend_nxt  = PC_NONE;
                phase_nxt = PH_IDLE;
              end
            end
            PH_WAIT_OUT: begin
              owr_nxt   = 1'b1;
              oval_nxt  = in_rx_byte;
              phase_nxt = PH_IDLE;
            end
            PH_WAIT_ADDR: begin
              if (in_button_held && in_address_store_ok) begin
                own_nxt = in_rx_byte[ADDR_W-1:0];
                led_nxt = hold_r;
              end
              phase_nxt = PH_IDLE;
            end
            default: begin
            end
          endcase
        end

        OP_TICK: begin
          if (phase_r == PH_READ_PENDING) begin
            if (pend_r == PC_DIN) begin
              reply_nxt[0] = in_digital_inputs;
            end else if (is_ain) begin
              reply_nxt[0] = adc_sel[BYTE_W-1:0];
              reply_nxt[1] = BYTE_W'(adc_sel[ADC_W-1:BYTE_W]);
              ridx_nxt     = REPLY_IDX_W'(1);
            end
            if ((pend_r == PC_DIN) || is_ain) begin
              phase_nxt    = PH_SENDING;
              txon_nxt     = 1'b1;
              tx_valid_nxt = 1'b1;
              tx_byte_nxt  = reply_nxt[0];
            end
          end
          if (led_r != '0) begin
            led_nxt = led_r - LED_W'(1);
            lit_nxt = 1'b1;
          end
        end

        OP_READY: begin
          if (phase_r == PH_SENDING) begin
            if (is_ain) begin
              if (ridx_r < REPLY_IDX_W'(REPLY_DEPTH)) begin
                tx_valid_nxt = 1'b1;
                tx_byte_nxt  = reply_r[ridx_r[REPLY_SEL_W-1:0]];
                ridx_nxt     = ridx_r + REPLY_IDX_W'(1);
                done         = 1'b0;
              end
            end else if (pend_r != PC_DIN) begin
              done = 1'b0;
            end
          end
          if (done) begin
            txon_nxt  = 1'b0;
            phase_nxt = PH_IDLE;
          end
        end

        default: begin
          // no-op event: result just reports the state
        end
      endcase
    end

    // Register writes are for the user to make only while no item is in flight; the block does not enforce it.
    if (cfg_wr) begin
      case (cfg_index)
        CFG_START_ADDR: begin
          start_nxt = cfg_data[ADDR_W-1:0];
          own_nxt   = cfg_data[ADDR_W-1:0];
        end
        CFG_LED_HOLD: hold_nxt = cfg_data[LED_W-1:0];
        default: begin
        end
      endcase
    end

    tx_en_nxt = txon_nxt;
    caddr_nxt = own_nxt;

    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pend_r      <= PC_NONE;
      ridx_r      <= '0;
      own_r       <= START_ADDR_RESET;
      led_r       <= '0;
      txon_r      <= 1'b0;
      start_r     <= START_ADDR_RESET;
      hold_r      <= LED_HOLD_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pend_r      <= pend_nxt;
      ridx_r      <= ridx_nxt;
      own_r       <= own_nxt;
      led_r       <= led_nxt;
      txon_r      <= txon_nxt;
      start_r     <= start_nxt;
      hold_r      <= hold_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // payload: no reset needed
    reply_r <= reply_nxt;
    if (accept) begin
      tx_valid_r <= tx_valid_nxt;
      tx_byte_r  <= tx_byte_nxt;
      tx_en_r    <= tx_en_nxt;
      owr_r      <= owr_nxt;
      oval_r     <= oval_nxt;
      lit_r      <= lit_nxt;
      caddr_r    <= caddr_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_tx_valid        = tx_valid_r;
  assign out_tx_byte         = tx_byte_r;
  assign out_tx_enabled      = tx_en_r;
  assign out_outputs_write   = owr_r;
  assign out_outputs_value   = oval_r;
  assign out_led_lit         = lit_r;
  assign out_current_address = caddr_r;

endmodule

`default_nettype wire

// ----- rtl/asio_checker.sv -----
// asio_checker: port-level checks for addressed_serial_io_command_slave,
// bound to the top level. Depends on asio_pkg.
`default_nettype none

module asio_checker
  import asio_pkg::*;
(
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_stall,
  input wire [OP_W-1:0]       in_operation,
  input wire                  out_valid,
  input wire                  out_stall,
  input wire                  out_tx_valid,
  input wire [BYTE_W-1:0]     out_tx_byte,
  input wire                  out_tx_enabled,
  input wire                  out_outputs_write
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_valid && out_stall) |->
      out_valid && $stable(out_tx_byte) && $stable(out_tx_valid))
    else $error("stalled result changed");

  // Empty result register never back-pressures the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // Received byte never sends a reply byte; result appears next cycle
  a_byte_no_tx: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation == OP_BYTE) |=> out_valid && !out_tx_valid)
    else $error("reply byte sent on a received byte");

  // Outputs are written only on a received byte
  a_owr_only_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_operation != OP_BYTE) |=> !out_outputs_write)
    else $error("outputs written on a non-byte item");

  // A sent byte leaves the transmitter enabled
  a_tx_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid |-> out_tx_enabled)
    else $error("reply byte with transmitter off");

endmodule

bind addressed_serial_io_command_slave asio_checker u_asio_checker (.*);

`default_nettype wire
